/* hw/rtl/wpss_pkg.sv */
// shared types and constants for the weighted path slot scheduler
`default_nettype none
package wpss_pkg;

  localparam int unsigned IDENT_W = 16;
  localparam int unsigned BW_W    = 32;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned SLOT_W  = 3;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SCHED = 1'b1
  } op_e;

  typedef enum logic {
    ST_CHOSEN = 1'b0,
    ST_NONE   = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIVI,
    S_DIVW,
    S_PICK,
    S_WALK,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

/* hw/rtl/wpss_if.sv */
// valid/ready channel interfaces for the scheduler input and result words
`default_nettype none
interface wpss_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [wpss_pkg::SLOT_W-1:0]    path_slot;
  logic [wpss_pkg::IDENT_W-1:0]   path_ident;
  logic [wpss_pkg::BW_W-1:0]      path_bandwidth;
  logic                           has_extension;

  modport source (output valid, operation, path_slot, path_ident, path_bandwidth,
                  has_extension, input ready);
  modport sink   (input valid, operation, path_slot, path_ident, path_bandwidth,
                  has_extension, output ready);
endinterface

interface wpss_out_if;
  logic                           valid;
  logic                           ready;
  logic [wpss_pkg::IDENT_W-1:0]   chosen_ident;
  logic [wpss_pkg::SEQ_W-1:0]     chosen_seq;
  logic                           status;

  modport source (output valid, chosen_ident, chosen_seq, status, input ready);
  modport sink   (input valid, chosen_ident, chosen_seq, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/weighted_path_slot_scheduler.sv */
// weighted multipath slot scheduler top level
//
//  channel | dir | words
//  in_i    | in  | add path entry or schedule one packet
//  out_o   | out | chosen path ident and sequence, one per schedule word
//
// a schedule word passes through accept, pick and result, with walk steps between pick and
// result when the extension flag starts the bit-reversed walk over an owned table; the walk
// tries slots below the largest power of two not above SLOT_COUNT
// the first schedule after a table change first rebuilds the slot shares: a scan over all
// MAX_PATHS entries, then one divide per present path on the divider
// reset clears control state only, no clearing pass is needed
// the result sits in an output register, so a new word is taken while it waits
`default_nettype none
module weighted_path_slot_scheduler #(
  parameter int unsigned MAX_PATHS  = 8,
  parameter int unsigned SLOT_COUNT = 128
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wpss_in_if.sink    in_i,
  wpss_out_if.source out_o
);

  localparam int unsigned LOG  = $clog2(SLOT_COUNT + 1) - 1;
  localparam int unsigned SIZE = 1 << LOG;
  localparam int unsigned SZW  = LOG + 1;
  localparam int unsigned PW   = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int unsigned CW   = $clog2(MAX_PATHS + 1);
  localparam int unsigned BW   = wpss_pkg::BW_W;
  localparam int unsigned SW   = BW + CW;
  localparam int unsigned NW   = BW + LOG;

  wpss_pkg::state_e state_q, state_d;

  logic [wpss_pkg::IDENT_W-1:0] ident_q [MAX_PATHS];
  logic [BW-1:0]                bw_q    [MAX_PATHS];
  logic [wpss_pkg::SEQ_W-1:0]   seq_q   [MAX_PATHS];
  logic [SZW-1:0]               end_q   [MAX_PATHS];
  logic [MAX_PATHS-1:0]         present_q;

  logic [PW-1:0]  p_q;
  logic [BW-1:0]  run_max_q;
  logic [SW-1:0]  sum_q;
  logic [CW-1:0]  cnt_q;
  logic [SZW-1:0] cum_q;
  logic [LOG-1:0] ctr_q;
  logic           ext_q;
  logic [PW-1:0]  pick_q;
  logic           found_q;
  logic [PW-1:0]  last_q;
  logic           last_vld_q;
  logic           dirty_q;

  logic                         out_valid_q;
  logic [wpss_pkg::IDENT_W-1:0] out_ident_q;
  logic [wpss_pkg::SEQ_W-1:0]   out_seq_q;
  logic                         out_status_q;

  logic           accept;
  logic           wr_ok;
  logic [PW-1:0]  wr_idx;
  logic           last_p;
  logic [BW-1:0]  bw_cur, rm_new, bw_new;
  logic           div_start, div_done;
  logic [NW-1:0]  div_num;
  logic [SW-1:0]  div_den;
  logic [SZW-1:0] quot;
  logic [LOG-1:0] rev;
  logic           hit;
  logic [PW-1:0]  owner;
  logic           out_load;
  logic           pick_ok, pick_walk;

  assign in_i.ready   = (state_q == wpss_pkg::S_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign wr_ok        = 32'(in_i.path_slot) < MAX_PATHS;
  assign wr_idx       = PW'(in_i.path_slot);
  assign last_p       = (p_q == PW'(MAX_PATHS - 1));

  assign out_o.valid        = out_valid_q;
  assign out_o.chosen_ident = out_ident_q;
  assign out_o.chosen_seq   = out_seq_q;
  assign out_o.status       = out_status_q;

  // running max fills in paths with no bandwidth report
  assign bw_cur = bw_q[p_q];
  assign rm_new = (bw_cur > run_max_q) ? bw_cur : run_max_q;
  assign bw_new = (bw_cur == '0) ? rm_new : bw_cur;

  assign div_start = (state_q == wpss_pkg::S_DIVI) && present_q[p_q];
  assign div_num   = (sum_q == '0) ? NW'(SIZE) : {bw_q[p_q], {LOG{1'b0}}};
  assign div_den   = (sum_q == '0) ? SW'(cnt_q) : sum_q;

  wpss_div #(.NW(NW), .DW(SW), .QW(SZW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // shares are laid out as contiguous runs in path order, so slot owner is a range lookup
  always_comb begin
    for (int i = 0; i < LOG; i++) begin
      rev[LOG-1-i] = ctr_q[i];
    end
    hit   = SZW'(rev) < end_q[MAX_PATHS-1];
    owner = '0;
    for (int p = MAX_PATHS - 1; p >= 0; p--) begin
      if (SZW'(rev) < end_q[p]) begin
        owner = PW'(p);
      end
    end
  end

  always_comb begin
    pick_ok   = 1'b0;
    pick_walk = 1'b0;
    if (present_q != '0) begin
      if (ext_q) begin
        pick_walk = end_q[MAX_PATHS-1] != '0;
      end else begin
        pick_ok = last_vld_q && present_q[last_q];
      end
    end
  end

  assign out_load = (state_q == wpss_pkg::S_RESP) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpss_pkg::S_IDLE: begin
        if (accept && in_i.operation == wpss_pkg::OP_SCHED) begin
          state_d = dirty_q ? wpss_pkg::S_SCAN : wpss_pkg::S_PICK;
        end
      end
      wpss_pkg::S_SCAN: if (last_p) state_d = wpss_pkg::S_DIVI;
      wpss_pkg::S_DIVI: begin
        if (present_q[p_q]) state_d = wpss_pkg::S_DIVW;
        else if (last_p) state_d = wpss_pkg::S_PICK;
      end
      wpss_pkg::S_DIVW: begin
        if (div_done) state_d = last_p ? wpss_pkg::S_PICK : wpss_pkg::S_DIVI;
      end
      wpss_pkg::S_PICK: state_d = pick_walk ? wpss_pkg::S_WALK : wpss_pkg::S_RESP;
      wpss_pkg::S_WALK: if (hit) state_d = wpss_pkg::S_RESP;
      wpss_pkg::S_RESP: if (out_load) state_d = wpss_pkg::S_IDLE;
      default: state_d = wpss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpss_pkg::S_IDLE;
      present_q   <= '0;
      dirty_q     <= 1'b1;
      last_vld_q  <= 1'b0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_i.operation == wpss_pkg::OP_ADD && wr_ok) begin
        present_q[wr_idx] <= 1'b1;
        dirty_q           <= 1'b1;
      end
      if ((state_q == wpss_pkg::S_DIVI && !present_q[p_q] && last_p) ||
          (state_q == wpss_pkg::S_DIVW && div_done && last_p)) begin
        dirty_q <= 1'b0;
        ctr_q   <= '0;
      end
      if (state_q == wpss_pkg::S_WALK) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        last_vld_q  <= found_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.operation == wpss_pkg::OP_ADD && wr_ok) begin
      ident_q[wr_idx] <= in_i.path_ident;
      bw_q[wr_idx]    <= in_i.path_bandwidth;
      seq_q[wr_idx]   <= '0;
    end
    if (accept && in_i.operation == wpss_pkg::OP_SCHED) begin
      ext_q     <= in_i.has_extension;
      p_q       <= '0;
      run_max_q <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end
    unique case (state_q)
      wpss_pkg::S_SCAN: begin
        if (present_q[p_q]) begin
          run_max_q <= rm_new;
          bw_q[p_q] <= bw_new;
          sum_q     <= sum_q + SW'(bw_new);
          cnt_q     <= cnt_q + 1'b1;
        end
        p_q   <= last_p ? '0 : p_q + 1'b1;
        cum_q <= '0;
      end
      wpss_pkg::S_DIVI: begin
        if (!present_q[p_q]) begin
          end_q[p_q] <= cum_q;
          if (!last_p) p_q <= p_q + 1'b1;
        end
      end
      wpss_pkg::S_DIVW: begin
        if (div_done) begin
          end_q[p_q] <= cum_q + quot;
          cum_q      <= cum_q + quot;
          if (!last_p) p_q <= p_q + 1'b1;
        end
      end
      wpss_pkg::S_PICK: begin
        found_q <= pick_ok;
        pick_q  <= last_q;
      end
      wpss_pkg::S_WALK: begin
        if (hit) begin
          found_q <= 1'b1;
          pick_q  <= owner;
        end
      end
      wpss_pkg::S_RESP: begin
        if (out_load) begin
          if (found_q) begin
            out_ident_q    <= ident_q[pick_q];
            out_seq_q      <= seq_q[pick_q] + 1'b1;
            seq_q[pick_q]  <= seq_q[pick_q] + 1'b1;
            out_status_q   <= wpss_pkg::ST_CHOSEN;
            last_q         <= pick_q;
          end else begin
            out_ident_q    <= '0;
            out_seq_q      <= '0;
            out_status_q   <= wpss_pkg::ST_NONE;
            last_q         <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/wpss_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module wpss_div #(
  parameter int unsigned NW = 39,
  parameter int unsigned DW = 36,
  parameter int unsigned QW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o
);

  localparam int unsigned TW  = DW + QW - 1;
  localparam int unsigned STW = (QW > 1) ? $clog2(QW) : 1;

  logic [NW-1:0]  rem_q;
  logic [DW-1:0]  den_q;
  logic [QW-1:0]  quot_q;
  logic [STW-1:0] step_q;
  logic           busy_q;
  logic           done_q;
  logic [TW-1:0]  trial;
  logic           fits;

  assign trial  = TW'(den_q) << step_q;
  assign fits   = TW'(rem_q) >= trial;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
      step_q <= STW'(QW - 1);
    end else if (busy_q) begin
      if (fits) begin
        rem_q          <= NW'(TW'(rem_q) - trial);
        quot_q[step_q] <= 1'b1;
      end
      if (step_q != '0) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/wpss_chk.sv */
// port-level checker for the scheduler, bound to the top level
`default_nettype none
module wpss_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_op_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_ident_i,
  input wire logic [15:0] out_seq_i,
  input wire logic        out_status_i
);

  // a schedule word leaves the block busy, not ready in the cycle after
  a_sched_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == wpss_pkg::OP_SCHED |=> !in_ready_i)
    else $error("ready after schedule word");

  // after an add word the block is ready again in the next cycle
  a_add_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == wpss_pkg::OP_ADD |=> in_ready_i)
    else $error("not ready after add word");

  // no-path result carries zero fields
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == wpss_pkg::ST_NONE |-> out_ident_i == '0 && out_seq_i == '0)
    else $error("no-path result with nonzero fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ident_i) &&
    $stable(out_seq_i) && $stable(out_status_i))
    else $error("stalled result word changed");

endmodule

bind weighted_path_slot_scheduler wpss_chk u_wpss_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.operation),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_ident_i  (out_o.chosen_ident),
  .out_seq_i    (out_o.chosen_seq),
  .out_status_i (out_o.status)
);
`default_nettype wire
